>>> src/rlp_pkg.sv
package rlp_pkg;

   // field widths fixed by the interface
   localparam int SymbolWidth = 16;
   localparam int CountWidth  = 3;
   localparam int CsrIdxWidth = 3;
   localparam int LabelCount  = 4;

   // configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CsrMaxReps     = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CsrLabelOne    = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CsrLabelTwo    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CsrLabelThree  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CsrLabelFour   = 3'd4;

   // repeat counts that select a label
   localparam logic [CountWidth-1:0] CountOne   = 3'd1;
   localparam logic [CountWidth-1:0] CountTwo   = 3'd2;
   localparam logic [CountWidth-1:0] CountThree = 3'd3;
   localparam logic [CountWidth-1:0] CountFour  = 3'd4;

   typedef struct packed {
      logic [SymbolWidth-1:0] token;
      logic                   seq_end;
   } rlp_req_type;

   typedef struct packed {
      logic [SymbolWidth-1:0] symbol;
      logic                   final_res;
   } rlp_rsp_type;

endpackage

>>> src/repeat_label_packer.sv
// channel  | ports                              | direction | transfer when
// ---------+------------------------------------+-----------+---------------------
// request  | req_valid, req_stall, req_data     | in        | valid && !stall
// response | rsp_valid, rsp_stall, rsp_data     | out       | valid && !stall
// csr      | csr_valid, csr_ready, csr_index/data | in      | valid && ready
//
// One request per cycle is taken while req_stall is low; it is held in the input register
// and its results are written to a two-entry output queue when it advances.
// A label-then-token request waits until the queue is empty after this cycle's pop.
// Reset (synchronous) clears the registers, the run state and the queue.
// The request side stalls while the held request has more results than the queue can take.
module repeat_label_packer #(
   parameter int MAX_REPEATS = 4,
   parameter int TOKEN_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rlp_pkg::rlp_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rlp_pkg::rlp_rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rlp_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [rlp_pkg::SymbolWidth-1:0]       csr_data
);
   import rlp_pkg::*;

   localparam int CmpWidth = (TOKEN_WIDTH < SymbolWidth) ? TOKEN_WIDTH : SymbolWidth;
   localparam int LimCap   = (MAX_REPEATS < LabelCount) ? MAX_REPEATS : LabelCount;

   // configuration registers
   logic [CountWidth-1:0]  max_reps_ff, max_reps_in;
   logic [SymbolWidth-1:0] label_ff [LabelCount];
   logic [SymbolWidth-1:0] label_in [LabelCount];

   // input register
   logic        in_valid_ff, in_valid_in;
   rlp_req_type in_item_ff, in_item_in;

   // run state
   logic [CmpWidth-1:0]   prev_ff, prev_in;
   logic                  prev_valid_ff, prev_valid_in;
   logic [CountWidth-1:0] count_ff, count_in;

   // output queue
   rlp_rsp_type q_ff [2];
   rlp_rsp_type q_in [2];
   logic [1:0]  q_cnt_ff, q_cnt_in;

   logic                  accept, advance, pop, is_rep, last;
   logic [CmpWidth-1:0]   tok;
   logic [CountWidth-1:0] lim, sel_count;
   logic [SymbolWidth-1:0] label_sel, tok_sym;
   rlp_rsp_type           r0, r1;
   logic [1:0]            n_res, base;
   logic [2:0]            fill;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      max_reps_in = max_reps_ff;
      label_in    = label_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrMaxReps:    max_reps_in = csr_data[CountWidth-1:0];
            CsrLabelOne:   label_in[0] = csr_data;
            CsrLabelTwo:   label_in[1] = csr_data;
            CsrLabelThree: label_in[2] = csr_data;
            CsrLabelFour:  label_in[3] = csr_data;
            default: ;
         endcase
      end
   end

   // label lookup for one count
   always_comb begin
      case (sel_count)
         CountOne:   label_sel = label_ff[0];
         CountTwo:   label_sel = label_ff[1];
         CountThree: label_sel = label_ff[2];
         CountFour:  label_sel = label_ff[3];
         default:    label_sel = '0;
      endcase
   end

   // result computation on the registered item
   assign tok     = in_item_ff.token[CmpWidth-1:0];
   assign tok_sym = SymbolWidth'(tok);
   assign last    = in_item_ff.seq_end;
   assign lim     = (max_reps_ff > CountWidth'(LimCap)) ? CountWidth'(LimCap) : max_reps_ff;
   assign is_rep  = prev_valid_ff && (tok == prev_ff) && (count_ff < lim);
   assign sel_count = is_rep ? count_ff + CountWidth'(1) : count_ff;

   always_comb begin
      r0 = '{symbol: tok_sym, final_res: last};
      r1 = '{symbol: tok_sym, final_res: last};
      if (is_rep) begin
         r0    = '{symbol: label_sel, final_res: 1'b1};
         n_res = last ? 2'd1 : 2'd0;
      end else if (count_ff != '0) begin
         r0    = '{symbol: label_sel, final_res: 1'b0};
         n_res = 2'd2;
      end else begin
         n_res = 2'd1;
      end
   end

   // queue space and handshakes
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign base      = q_cnt_ff - {1'b0, pop};
   assign fill      = {1'b0, base} + {1'b0, n_res};
   assign advance   = in_valid_ff && (fill <= 3'd2);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !advance);
      in_item_in  = accept ? req_data : in_item_ff;
   end

   // run state update
   always_comb begin
      prev_in       = prev_ff;
      prev_valid_in = prev_valid_ff;
      count_in      = count_ff;
      if (advance) begin
         if (last) begin
            prev_in       = '0;
            prev_valid_in = 1'b0;
            count_in      = '0;
         end else if (is_rep) begin
            count_in = count_ff + CountWidth'(1);
         end else begin
            prev_in       = tok;
            prev_valid_in = 1'b1;
            count_in      = '0;
         end
      end
   end

   // queue shift and fill
   always_comb begin
      q_in = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (advance) begin
         case (base)
            2'd0: begin
               q_in[0] = r0;
               q_in[1] = r1;
            end
            2'd1: q_in[1] = r0;
            default: ;
         endcase
      end
      q_cnt_in = advance ? fill[1:0] : base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_reps_ff   <= '0;
         label_ff      <= '{default: '0};
         in_valid_ff   <= 1'b0;
         prev_ff       <= '0;
         prev_valid_ff <= 1'b0;
         count_ff      <= '0;
         q_cnt_ff      <= '0;
      end else begin
         max_reps_ff   <= max_reps_in;
         label_ff      <= label_in;
         in_valid_ff   <= in_valid_in;
         prev_ff       <= prev_in;
         prev_valid_ff <= prev_valid_in;
         count_ff      <= count_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      q_ff       <= q_in;
   end

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 2'd2)
      else $error("output queue overfilled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(LabelCount))
      else $error("repeat count beyond label range");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      advance && last |=> !prev_valid_ff && (count_ff == '0))
      else $error("run state not cleared after sequence end");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (q_cnt_ff == 2'd2) && rsp_stall && (n_res != 2'd0) |-> req_stall)
      else $error("request taken while queue blocked");

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rlp_pkg::*;

   // one pending token with an optional wait for all symbols to drain first
   typedef struct {
      rlp_req_type req;
      bit          hold;
   } token_slot_type;

   // limit per random phase, phase 0 in the low bits
   localparam logic [5:0][CountWidth-1:0] RepsPlan = {3'd3, 3'd0, 3'd7, 3'd1, 3'd4, 3'd2};

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   rlp_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rlp_rsp_type            rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = CsrMaxReps;
   logic [SymbolWidth-1:0] csr_data  = '0;

   token_slot_type token_backlog[$];
   rlp_rsp_type due_symbols[$];

   // shadow registers and run state
   logic [CountWidth-1:0]  max_reps = '0;
   logic [SymbolWidth-1:0] labels[LabelCount] = '{default: '0};
   logic [SymbolWidth-1:0] prev_token = '0;
   logic                   prev_live  = 1'b0;
   logic [CountWidth-1:0]  run_extra  = '0;

   int send_gap_pct = 11;
   int recv_gap_pct = 45;
   bit req_took = 1'b0;
   bit csr_took = 1'b0;
   int fail_count = 0;
   int token_count = 0;
   int seq_count = 0;
   int symbol_count = 0;
   int folded_count = 0;

   repeat_label_packer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // label register selected by a repeat count
   function automatic logic [SymbolWidth-1:0] label_for(logic [CountWidth-1:0] count);
      case (count)
         CountOne:   return labels[0];
         CountTwo:   return labels[1];
         CountThree: return labels[2];
         CountFour:  return labels[3];
         default:    return '0;
      endcase
   endfunction

   // fold one token into the run state and queue the symbols it releases
   function automatic void pack_token(rlp_req_type r);
      rlp_rsp_type           outs[2];
      int                    n;
      logic [CountWidth-1:0] lim;
      n = 0;
      lim = (max_reps > CountFour) ? CountFour : max_reps;
      if (prev_live && r.token == prev_token && run_extra < lim) begin
         run_extra = run_extra + 1'b1;
      end else begin
         if (run_extra != '0) begin
            outs[n] = '{symbol: label_for(run_extra), final_res: 1'b0};
            n++;
            folded_count++;
            run_extra = '0;
         end
         outs[n] = '{symbol: r.token, final_res: 1'b0};
         n++;
         prev_token = r.token;
         prev_live = 1'b1;
      end
      // sequence end flushes any pending label and clears the run
      if (r.seq_end) begin
         if (run_extra != '0) begin
            outs[n] = '{symbol: label_for(run_extra), final_res: 1'b0};
            n++;
            folded_count++;
         end
         outs[n-1].final_res = 1'b1;
         prev_token = '0;
         prev_live = 1'b0;
         run_extra = '0;
      end
      for (int i = 0; i < n; i++) due_symbols = {due_symbols, outs[i]};
   endfunction

   function automatic void push_tok(logic [SymbolWidth-1:0] tok, logic last, bit hold = 1'b0);
      token_slot_type s;
      s.req.token = tok;
      s.req.seq_end = last;
      s.hold = hold;
      token_backlog = {token_backlog, s};
   endfunction

   // mostly runs of repeated tokens closed by an end marker, some noise and open sequences
   function automatic void queue_sequences(int want);
      logic [SymbolWidth-1:0] pool[4];
      logic [SymbolWidth-1:0] tok;
      int                     added;
      int                     runs;
      int                     reps;
      bit                     open_end;
      added = 0;
      for (int k = 0; k < 4; k++) pool[k] = 16'($urandom);
      while (added < want) begin
         if ($urandom_range(99) < 12) begin
            push_tok(16'($urandom), 1'($urandom_range(1)));
            added++;
         end else begin
            runs = $urandom_range(4, 1);
            open_end = ($urandom_range(9) == 0);
            for (int r = 0; r < runs; r++) begin
               tok = ($urandom_range(3) == 0) ? 16'($urandom) : pool[$urandom_range(3)];
               reps = $urandom_range(7, 1);
               for (int j = 0; j < reps; j++) begin
                  push_tok(tok, (r == runs - 1) && (j == reps - 1) && !open_end,
                           (r == 0) && (j == 0) && ($urandom_range(39) == 0));
                  added++;
               end
            end
         end
      end
   endfunction

   // one register write transfer
   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [SymbolWidth-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (!csr_took);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [CountWidth-1:0] reps,
                           input logic [SymbolWidth-1:0] one, two, three, four);
      write_csr(CsrMaxReps, {{(SymbolWidth - CountWidth){1'b0}}, reps});
      write_csr(CsrLabelOne, one);
      write_csr(CsrLabelTwo, two);
      write_csr(CsrLabelThree, three);
      write_csr(CsrLabelFour, four);
   endtask

   // all tokens sent, all symbols back, then an idle pause
   task automatic wait_idle();
      while (token_backlog.size() != 0 || req_valid || due_symbols.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // token driver
   always @(negedge clock) begin : feed_tokens
      token_slot_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (token_backlog.size() != 0
             && !(token_backlog[0].hold && due_symbols.size() != 0)
             && $urandom_range(99) >= send_gap_pct) begin
            nxt = token_backlog.pop_front();
            req_valid <= 1'b1;
            req_data  <= nxt.req;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin : stall_symbols
      rsp_stall <= ($urandom_range(99) < recv_gap_pct);
   end

   // monitor: check symbol transfers, predict on token and register transfers
   always @(posedge clock) begin : observe
      rlp_rsp_type want;
      if (reset) begin
         req_took <= 1'b0;
         csr_took <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            symbol_count++;
            if (due_symbols.size() == 0) begin
               $error("symbol transfer with nothing expected: symbol %h final_res %b",
                      rsp_data.symbol, rsp_data.final_res);
               fail_count++;
            end else begin
               want = due_symbols.pop_front();
               if (rsp_data.symbol !== want.symbol) begin
                  $error("symbol: expected %h, got %h", want.symbol, rsp_data.symbol);
                  fail_count++;
               end
               if (rsp_data.final_res !== want.final_res) begin
                  $error("final_res: expected %b, got %b", want.final_res, rsp_data.final_res);
                  fail_count++;
               end
            end
         end
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            token_count++;
            if (req_data.seq_end) seq_count++;
            pack_token(req_data);
         end
         csr_took <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrMaxReps:    max_reps = csr_data[CountWidth-1:0];
               CsrLabelOne:   labels[0] = csr_data;
               CsrLabelTwo:   labels[1] = csr_data;
               CsrLabelThree: labels[2] = csr_data;
               CsrLabelFour:  labels[3] = csr_data;
               default: ;
            endcase
         end
      end
   end

   initial begin : run_phases
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // packing off after reset: repeats pass through
      push_tok(16'h0000, 1'b0);
      push_tok(16'hFFFF, 1'b0);
      push_tok(16'hFFFF, 1'b1);
      wait_idle();

      // full limit, extreme label values
      set_regs(3'd4, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A);
      push_tok(16'h0007, 1'b0);
      push_tok(16'h0007, 1'b0);
      push_tok(16'h0009, 1'b0);
      // run hits the limit and the next repeat starts a new run
      repeat (4) push_tok(16'h0009, 1'b0);
      push_tok(16'h0009, 1'b1);
      // sequence ends with a label pending
      push_tok(16'h0005, 1'b0);
      push_tok(16'h0005, 1'b0);
      push_tok(16'h0005, 1'b1);
      // first token of a sequence equal to the last one before it
      push_tok(16'h0005, 1'b1);
      // leave a run of two extra repeats open
      push_tok(16'h0006, 1'b0);
      push_tok(16'h0006, 1'b0);
      push_tok(16'h0006, 1'b0);
      wait_idle();

      // limit lowered with a count pending
      write_csr(CsrMaxReps, 16'd1);
      push_tok(16'h0006, 1'b0);
      push_tok(16'h0008, 1'b0);
      push_tok(16'h0008, 1'b0);
      wait_idle();

      // packing switched off with a label pending
      write_csr(CsrMaxReps, 16'd0);
      push_tok(16'h0008, 1'b1);
      wait_idle();

      // limit above the label range
      set_regs(3'd7, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      push_tok(16'h0001, 1'b0, 1'b1);
      repeat (4) push_tok(16'h0001, 1'b0);
      push_tok(16'h0001, 1'b1);

      // random phases: sender idles less, then receiver idles less, then no idling
      for (int ph = 0; ph < 6; ph++) begin
         wait_idle();
         send_gap_pct = (ph < 2) ? 11 : (ph < 4) ? 45 : 0;
         recv_gap_pct = (ph < 2) ? 45 : (ph < 4) ? 11 : 0;
         set_regs(RepsPlan[ph], 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         queue_sequences(237);
      end
      wait_idle();

      $display("checked %0d symbols (%0d repeat labels) from %0d tokens, %0d sequence ends",
               symbol_count, folded_count, token_count, seq_count);
      $display("limits 0 to 7 incl. mid-run changes, all label registers, varied back-pressure");
      if (fail_count == 0) begin
         $display("repeat_label_packer: match");
      end else begin
         $display("repeat_label_packer: mismatch");
      end
      $finish;
   end

   // run time limit
   initial begin : watchdog
      #2_400_000;
      $display("repeat_label_packer: mismatch");
      $finish;
   end

endmodule
